// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the table logic.
// Both expect clk and rst in scope; checks are off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gtpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gtpt_pkg;

  localparam int HASH_W   = 64;
  localparam int TURN_W   = 15;
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 16;
  localparam int COUNT_W  = 17;

  localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_NEW_GEN = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_NONE = 1'b1;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic signed [HASH_W-1:0] position_hash;
    logic [TURN_W-1:0]        turn_count;
  } gtpt_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } gtpt_state_t;

endpackage

`default_nettype wire

// ----- hdl/gtpt_query_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface gtpt_query_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [63:0] position_hash;
  logic [14:0]        turn_count;

  modport source (output valid, output action, output position_hash, output turn_count,
                  input ready);
  modport sink (input valid, input action, input position_hash, input turn_count,
                output ready);
endinterface

`default_nettype wire

// ----- hdl/gtpt_reply_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface gtpt_reply_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] slot_index;
  logic [16:0] live_count;

  modport source (output valid, output status, output slot_index, output live_count,
                  input ready);
  modport sink (input valid, input status, input slot_index, input live_count,
                output ready);
endinterface

`default_nettype wire

// ----- hdl/gtpt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gtpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/gtpt_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gtpt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gtpt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gtpt_front
  import gtpt_pkg::*;
#(
  parameter int TABLE_SLOTS = 65536,
  localparam int SLOT_W = $clog2(TABLE_SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  gtpt_query_if.sink        query,
  input  logic              hold,
  output logic              push_valid,
  input  logic              push_ready,
  output gtpt_item_t        push_item,
  output logic [SLOT_W-1:0] push_home
);

  localparam bit SLOTS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam int NIBBLE_W = 4;
  localparam int NIBBLES  = HASH_W / NIBBLE_W;

  // Residue of 16^i modulo the table size, one per hash nibble.
  function automatic logic [NIBBLES*SLOT_W-1:0] fold_weights();
    logic [NIBBLES*SLOT_W-1:0] w;
    longint unsigned           k;
    w = '0;
    k = 64'd1;
    for (int i = 0; i < NIBBLES; i++) begin
      w[SLOT_W*i +: SLOT_W] = SLOT_W'(k);
      k = (k << NIBBLE_W) % 64'(TABLE_SLOTS);
    end
    return w;
  endfunction

  gtpt_item_t query_item;

  assign query_item.action        = query.action;
  assign query_item.position_hash = query.position_hash;
  assign query_item.turn_count    = query.turn_count;

  if (SLOTS_POW2) begin : g_mask
    // Home slot is just the low bits of the hash.
    assign query.ready = push_ready && !hold;
    assign push_valid  = query.valid && !hold;
    assign push_item   = query_item;
    assign push_home   = query.position_hash[SLOT_W-1:0];
  end else begin : g_reduce
    localparam int STEP_W = 2;
    localparam int QUO_W  = 9;
    localparam int SUM_W  = SLOT_W + 8;
    localparam int PROD_W = SUM_W + QUO_W;
    localparam int WIDE_W = SLOT_W + 1;
    localparam logic [STEP_W-1:0] STEP_END = 2'd2;
    localparam logic [NIBBLES*SLOT_W-1:0] FOLD_K = fold_weights();
    localparam logic [QUO_W-1:0] RECIP = QUO_W'((64'd1 << SUM_W) / 64'(TABLE_SLOTS));
    localparam logic [SUM_W-1:0] MOD_SUM = SUM_W'(TABLE_SLOTS);
    localparam logic [WIDE_W-1:0] MODULUS = WIDE_W'(TABLE_SLOTS);

    logic              busy;
    logic [STEP_W-1:0] step;
    gtpt_item_t        item;
    logic [SUM_W-1:0]  fold_sum;
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    logic [QUO_W-1:0]  quo;
    logic [SUM_W-1:0]  diff;
    logic [WIDE_W-1:0] part_rem;
    logic [SLOT_W-1:0] rem;
    logic [SLOT_W-1:0] rem_next;

    // Weight each hash nibble by its residue; the sum stays below 256 * TABLE_SLOTS.
    always_comb begin
      fold_sum = '0;
      for (int i = 0; i < NIBBLES; i++) begin
        fold_sum = fold_sum + SUM_W'(query.position_hash[NIBBLE_W*i +: NIBBLE_W])
                   * SUM_W'(FOLD_K[SLOT_W*i +: SLOT_W]);
      end
    end

    // Reciprocal estimate of the quotient is short by at most one.
    assign prod     = PROD_W'(sum) * PROD_W'(RECIP);
    assign diff     = sum - SUM_W'(quo) * MOD_SUM;
    assign part_rem = diff[WIDE_W-1:0];
    assign rem_next = (part_rem >= MODULUS) ? SLOT_W'(part_rem - MODULUS)
                                            : part_rem[SLOT_W-1:0];

    assign query.ready = !busy && !hold;
    assign push_valid  = busy && (step == STEP_END);
    assign push_item   = item;
    assign push_home   = rem;

    always_ff @(posedge clk) begin
      if (rst) begin
        busy <= 1'b0;
        step <= '0;
      end else if (query.valid && query.ready) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy && step != STEP_END) begin
        step <= step + 1'b1;
      end else if (push_valid && push_ready) begin
        busy <= 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (query.valid && query.ready) begin
        item <= query_item;
        sum  <= fold_sum;
      end
      quo <= prod[SUM_W +: QUO_W];
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gtpt_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gtpt_back
  import gtpt_pkg::*;
#(
  parameter int TABLE_SLOTS = 65536,
  parameter int GENERATION_BITS = 16,
  localparam int SLOT_W = $clog2(TABLE_SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  gtpt_item_t        pop_item,
  input  logic [SLOT_W-1:0] pop_home,
  output logic              clearing,
  gtpt_reply_if.source      reply
);

  localparam int ENTRY_W = GENERATION_BITS + TURN_W + HASH_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [GENERATION_BITS-1:0] GEN_ONE = GENERATION_BITS'(1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  gtpt_state_t                state, state_next;
  logic [SLOT_W-1:0]          clr_addr, clr_addr_next;
  logic [GENERATION_BITS-1:0] cur_gen, cur_gen_next;
  logic [COUNT_W-1:0]         live, live_next;
  gtpt_item_t                 item, item_next;
  logic [SLOT_W-1:0]          probe_slot, probe_slot_next;
  logic [SLOT_W-1:0]          probe_n, probe_n_next;
  logic                       res_status, res_status_next;
  logic [INDEX_W-1:0]         res_slot, res_slot_next;
  logic                       out_valid, out_valid_next;
  logic                       out_status;
  logic [INDEX_W-1:0]         out_slot;
  logic [COUNT_W-1:0]         out_count;
  logic                       load_out;

  logic                       ram_we;
  logic [SLOT_W-1:0]          ram_waddr;
  logic [ENTRY_W-1:0]         ram_wdata;
  logic [SLOT_W-1:0]          ram_raddr;
  logic [ENTRY_W-1:0]         ram_rdata;

  logic [GENERATION_BITS-1:0] rd_gen;
  logic [TURN_W-1:0]          rd_turn;
  logic [HASH_W-1:0]          rd_hash;
  logic                       stale;
  logic                       match;
  logic                       lap_end;
  logic                       out_free;
  logic [SLOT_W-1:0]          slot_after;
  logic [SLOT_W+INDEX_W-1:0]  slot_ext;
  logic [INDEX_W-1:0]         slot16;

  gtpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_gen  = ram_rdata[ENTRY_W-1 -: GENERATION_BITS];
  assign rd_turn = ram_rdata[HASH_W +: TURN_W];
  assign rd_hash = ram_rdata[HASH_W-1:0];

  // Read data always belongs to probe_slot while probing.
  assign stale   = (rd_gen != cur_gen);
  assign match   = !stale && (rd_hash == item.position_hash) && (rd_turn == item.turn_count);
  assign lap_end = (probe_n == LAST_SLOT);

  assign slot_after = (probe_slot == LAST_SLOT) ? '0 : probe_slot + 1'b1;
  assign slot_ext   = {{INDEX_W{1'b0}}, probe_slot};
  assign slot16     = slot_ext[INDEX_W-1:0];
  assign out_free   = !out_valid || reply.ready;
  assign clearing   = (state == ST_CLEAR);

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    cur_gen_next    = cur_gen;
    live_next       = live;
    item_next       = item;
    probe_slot_next = probe_slot;
    probe_n_next    = probe_n;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    out_valid_next  = out_valid && !reply.ready;
    load_out        = 1'b0;
    pop_ready       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = probe_slot;
    ram_wdata       = {cur_gen, item.turn_count, item.position_hash};
    // Fetch the following slot ahead of the decision on this one.
    ram_raddr       = slot_after;

    case (state)
      ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_SLOT) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        pop_ready = 1'b1;
        ram_raddr = pop_home;
        if (pop_valid) begin
          item_next       = pop_item;
          probe_slot_next = pop_home;
          probe_n_next    = '0;
          res_slot_next   = '0;
          case (pop_item.action)
            ACT_INSERT, ACT_LOOKUP: begin
              state_next = ST_PROBE;
            end
            ACT_NEW_GEN: begin
              cur_gen_next    = cur_gen + GEN_ONE;
              live_next       = '0;
              res_status_next = STATUS_OK;
              state_next      = ST_DONE;
            end
            default: begin
              res_status_next = STATUS_NONE;
              state_next      = ST_DONE;
            end
          endcase
        end
      end
      ST_PROBE: begin
        probe_slot_next = slot_after;
        probe_n_next    = probe_n + 1'b1;
        if (item.action == ACT_INSERT) begin
          if (stale) begin
            // Claim this slot.
            ram_we          = 1'b1;
            live_next       = (live == COUNT_MAX) ? live : live + 1'b1;
            res_status_next = STATUS_OK;
            res_slot_next   = slot16;
            state_next      = ST_DONE;
          end else if (lap_end) begin
            res_status_next = STATUS_NONE;
            res_slot_next   = '0;
            state_next      = ST_DONE;
          end
        end else begin
          if (match) begin
            res_status_next = STATUS_OK;
            res_slot_next   = slot16;
            state_next      = ST_DONE;
          end else if (stale || lap_end) begin
            res_status_next = STATUS_NONE;
            res_slot_next   = '0;
            state_next      = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      cur_gen   <= GEN_ONE;
      live      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      cur_gen   <= cur_gen_next;
      live      <= live_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item       <= item_next;
    probe_slot <= probe_slot_next;
    probe_n    <= probe_n_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    if (load_out) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_count  <= live;
    end
  end

  assign reply.valid      = out_valid;
  assign reply.status     = out_status;
  assign reply.slot_index = out_slot;
  assign reply.live_count = out_count;

  `ASSERT_IMPLIES(a_claim_stale_only, ram_we && state == ST_PROBE,
    stale && item.action == ACT_INSERT, "table write while probing hit a live slot")
  `ASSERT_NEXT(a_new_gen_resets_count,
    state == ST_IDLE && pop_valid && pop_item.action == ACT_NEW_GEN,
    live == '0 && cur_gen == $past(cur_gen) + GEN_ONE, "generation bump not applied")
  `ASSERT_IMPLIES(a_clear_quiet, state == ST_CLEAR, !out_valid && !pop_ready,
    "transaction moved during table clear")

endmodule

`default_nettype wire

// ----- hdl/generation_tagged_probe_table_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Linear-probing table of position entries tagged with a generation number.
// After reset the block sweeps the table once to zero every generation tag
// and holds query.ready low until the sweep ends. Each insert or lookup
// then examines slots in the probe engine, one per cycle and at most
// TABLE_SLOTS of them; the table memory has one read and one write port
// and its read is registered. With a power-of-two TABLE_SLOTS the home
// slot is the low bits of the hash and the front adds no delay; otherwise
// the front folds the hash nibbles by their residues and finishes the
// reduction with a reciprocal multiplication, registering the folded sum,
// the quotient estimate and the remainder in turn and taking no new item
// until the last one is pushed; it overlaps with the probe engine through
// a two-entry queue. A finished result waits in an output register while
// the next item is already taken.
module generation_tagged_probe_table_core
  import gtpt_pkg::*;
#(
  parameter int TABLE_SLOTS = 65536,
  parameter int GENERATION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  gtpt_query_if.sink   query,
  gtpt_reply_if.source reply
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int QUEUE_W = $bits(gtpt_item_t) + SLOT_W;

  logic              hold;
  logic              push_valid;
  logic              push_ready;
  gtpt_item_t        push_item;
  logic [SLOT_W-1:0] push_home;
  logic              pop_valid;
  logic              pop_ready;
  gtpt_item_t        pop_item;
  logic [SLOT_W-1:0] pop_home;
  logic [QUEUE_W-1:0] pop_data;

  gtpt_front #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .query      (query),
    .hold       (hold),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .push_home  (push_home)
  );

  gtpt_queue #(
    .WIDTH (QUEUE_W),
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_item, push_home}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_item = pop_data[QUEUE_W-1:SLOT_W];
  assign pop_home = pop_data[SLOT_W-1:0];

  gtpt_back #(
    .TABLE_SLOTS     (TABLE_SLOTS),
    .GENERATION_BITS (GENERATION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .pop_home  (pop_home),
    .clearing  (hold),
    .reply     (reply)
  );

endmodule

`default_nettype wire

// ----- tb/gtpt_checker.sv -----
`timescale 1ns / 1ps

module gtpt_checker
  import gtpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  gtpt_query_if query,
  gtpt_reply_if reply,
  output int    mismatches,
  output int    outstanding,
  output int    checked
);

  localparam int SLOTS    = 65536;
  localparam int GEN_BITS = 16;

  typedef struct packed {
    logic               status;
    logic [INDEX_W-1:0] slot;
    logic [COUNT_W-1:0] count;
  } table_reply_t;

  // Shadow copy of the table and its bookkeeping
  logic [HASH_W-1:0]   slot_hash [SLOTS];
  logic [TURN_W-1:0]   slot_turn [SLOTS];
  logic [GEN_BITS-1:0] slot_gen  [SLOTS];
  logic [GEN_BITS-1:0] generation;
  logic [COUNT_W-1:0]  claimed;

  table_reply_t pending_replies[$];
  int           fail_tally;
  int           reply_tally;

  function automatic table_reply_t probe_table(input logic [ACTION_W-1:0] action,
                                               input logic [HASH_W-1:0] hash,
                                               input logic [TURN_W-1:0] turn);
    table_reply_t res;
    int unsigned  idx;
    res.status = STATUS_NONE;
    res.slot   = '0;
    idx        = int'(hash % 64'(SLOTS));
    case (action)
      ACT_INSERT: begin
        for (int n = 0; n < SLOTS; n++) begin
          // claim the first slot not tagged with the current generation
          if (slot_gen[idx] != generation) begin
            slot_hash[idx] = hash;
            slot_turn[idx] = turn;
            slot_gen[idx]  = generation;
            if (claimed != '1) claimed++;
            res.status = STATUS_OK;
            res.slot   = INDEX_W'(idx);
            break;
          end
          idx = (idx + 1) % SLOTS;
        end
      end
      ACT_LOOKUP: begin
        for (int n = 0; n < SLOTS; n++) begin
          if (slot_gen[idx] != generation) break;
          if (slot_hash[idx] == hash && slot_turn[idx] == turn) begin
            res.status = STATUS_OK;
            res.slot   = INDEX_W'(idx);
            break;
          end
          idx = (idx + 1) % SLOTS;
        end
      end
      ACT_NEW_GEN: begin
        generation++;
        claimed    = '0;
        res.status = STATUS_OK;
      end
      default: ;
    endcase
    res.count = claimed;
    return res;
  endfunction

  task automatic report_failure(input string what, input table_reply_t want,
                                input table_reply_t got);
    fail_tally++;
    if (fail_tally <= 10)
      $display("%0t: %s: expected status %0d slot %0d count %0d, got status %0d slot %0d count %0d",
               $time, what, want.status, want.slot, want.count,
               got.status, got.slot, got.count);
  endtask

  initial begin
    fail_tally  = 0;
    reply_tally = 0;
  end

  always @(posedge clk) begin
    table_reply_t got;
    table_reply_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_gen[i] = '0;
      generation = GEN_BITS'(1);
      claimed    = '0;
      pending_replies.delete();
    end else begin
      // retire before predicting: a reply never belongs to the query taken on the same edge
      if (reply.valid && reply.ready) begin
        got = '{status: reply.status, slot: reply.slot_index, count: reply.live_count};
        reply_tally++;
        if (pending_replies.size() == 0) begin
          report_failure("reply with no transaction outstanding", '0, got);
        end else begin
          want = pending_replies.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.count !== want.count)
            report_failure("reply mismatch", want, got);
        end
      end
      if (query.valid && query.ready)
        pending_replies.push_back(probe_table(query.action, query.position_hash,
                                              query.turn_count));
    end
    mismatches  <= fail_tally;
    outstanding <= pending_replies.size();
    checked     <= reply_tally;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import gtpt_pkg::*;

  localparam int IDLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES  = 160;
  localparam int RANDOM_ITEMS = 450;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic hold_now;
  logic [HASH_W-1:0] live_hash[$];
  logic [TURN_W-1:0] live_turn[$];
  int n_insert, n_lookup, n_new_gen, n_unused;
  int mismatches, outstanding, checked;

  gtpt_query_if query ();
  gtpt_reply_if reply ();

  generation_tagged_probe_table_core dut (
    .clk  (clk),
    .rst  (rst),
    .query(query),
    .reply(reply)
  );

  gtpt_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .query      (query),
    .reply      (reply),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_query(input logic [ACTION_W-1:0] act, input logic [HASH_W-1:0] h,
                            input logic [TURN_W-1:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      query.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    query.valid         = 1'b1;
    query.action        = act;
    query.position_hash = h;
    query.turn_count    = t;
    do @(posedge clk); while (!query.ready);
    case (act)
      ACT_INSERT: begin
        n_insert++;
        live_hash.push_back(h);
        live_turn.push_back(t);
      end
      ACT_LOOKUP: n_lookup++;
      ACT_NEW_GEN: begin
        n_new_gen++;
        live_hash.delete();
        live_turn.delete();
      end
      default: n_unused++;
    endcase
  endtask

  initial begin : receiver
    int   stall;
    logic held;
    stall       = 0;
    held        = 1'b0;
    reply.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_now && !held) begin
        // hold off long enough for the block to back up and stall its input
        held        = 1'b1;
        reply.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall > 0) begin
        reply.ready = 1'b0;
        stall--;
      end else begin
        stall       = pick_gap();
        reply.ready = (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((query.valid && query.ready) || (reply.valid && reply.ready)) idle = 0;
      else idle++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    int                pick;
    int                idx;
    logic [HASH_W-1:0] h;
    logic [TURN_W-1:0] t;
    logic [15:0]       cluster_base;

    rst                 = 1'b1;
    hold_now            = 1'b0;
    n_insert            = 0;
    n_lookup            = 0;
    n_new_gen           = 0;
    n_unused            = 0;
    query.valid         = 1'b0;
    query.action        = ACT_INSERT;
    query.position_hash = '0;
    query.turn_count    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Extremes, wraparound past the last slot, duplicates, collisions, unused code
    send_query(ACT_LOOKUP, 64'h0, 15'h0);
    send_query(ACT_INSERT, 64'h8000_0000_0000_0000, 15'h0);
    send_query(ACT_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 15'h7FFF);
    send_query(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 15'h7FFF);
    send_query(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 15'h7FFF);
    send_query(ACT_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 15'h7FFE);
    send_query(ACT_LOOKUP, 64'h8000_0000_0000_0000, 15'h0);
    send_query(ACT_INSERT, 64'h8000_0000_0000_0000, 15'h0);
    send_query(ACT_LOOKUP, 64'h8000_0000_0000_0000, 15'h0);
    send_query(ACT_INSERT, 64'h5555_5555_5555_1234, 15'h2AAA);
    send_query(ACT_INSERT, 64'hAAAA_AAAA_AAAA_1234, 15'h5555);
    send_query(ACT_LOOKUP, 64'hAAAA_AAAA_AAAA_1234, 15'h5555);
    send_query(ACT_LOOKUP, 64'h1234_0000_0000_1234, 15'h2AAA);
    send_query(ACT_UNUSED, 64'h7FFF_FFFF_FFFF_FFFF, 15'h7FFF);
    send_query(ACT_NEW_GEN, 64'h0, 15'h0);
    send_query(ACT_LOOKUP, 64'h8000_0000_0000_0000, 15'h0);
    send_query(ACT_INSERT, 64'h8000_0000_0000_0000, 15'h7FFF);

    cluster_base = 16'($urandom);
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 40) hold_now = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick >= 94 && pick < 98) begin
        send_query(ACT_NEW_GEN, {$urandom, $urandom}, 15'($urandom));
        cluster_base = 16'($urandom);
      end else if (pick < 40 || live_hash.size() == 0) begin
        h = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0)
          h[15:0] = cluster_base + 16'($urandom_range(0, 23));
        if (pick < 4) h[63:16] = pick[0] ? '1 : '0;
        t = (pick < 2) ? 15'h7FFF : 15'($urandom);
        send_query(ACT_INSERT, h, t);
      end else if (pick < 75) begin
        idx = $urandom_range(0, live_hash.size() - 1);
        send_query(ACT_LOOKUP, live_hash[idx], live_turn[idx]);
      end else if (pick < 90) begin
        // near miss: flip one bit of a stored key
        idx = $urandom_range(0, live_hash.size() - 1);
        h   = live_hash[idx];
        t   = live_turn[idx];
        if (pick[0]) t[$urandom_range(0, TURN_W - 1)] ^= 1'b1;
        else h[$urandom_range(16, HASH_W - 1)] ^= 1'b1;
        send_query(ACT_LOOKUP, h, t);
      end else if (pick < 94) begin
        send_query(ACT_UNUSED, {$urandom, $urandom}, 15'($urandom));
      end else begin
        send_query(ACT_LOOKUP, {$urandom, $urandom}, 15'($urandom));
      end
    end

    @(negedge clk);
    query.valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d inserts, %0d lookups, %0d generation bumps, %0d unused codes.",
             n_insert, n_lookup, n_new_gen, n_unused);
    $display("Clustered home slots, wrap past the last slot and a long reply stall; %0d replies checked.",
             checked);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
